/* rtl/fgf_pkg.sv */
// Shared types and constants of the font ROM glyph fetch block.
`default_nettype none
package fgf_pkg;

  typedef enum logic [1:0] {
    CMD_GBK   = 2'd0,
    CMD_ASCII = 2'd1,
    CMD_RX    = 2'd2
  } cmd_t;

  localparam int unsigned WIDE_GLYPH_BYTES   = 32;
  localparam int unsigned NARROW_GLYPH_BYTES = 16;
  localparam int unsigned HEADER_BYTES       = 4;

  localparam logic [7:0]  ROM_READ_CMD  = 8'h03;
  localparam logic [7:0]  DUMMY_BYTE    = 8'h00;
  localparam logic [7:0]  HZ_ROW_FIRST  = 8'hb0;
  localparam logic [7:0]  HZ_ROW_LAST   = 8'hf7;
  localparam logic [7:0]  SYM_ROW_FIRST = 8'ha1;
  localparam logic [7:0]  SYM_ROW_LAST  = 8'ha9;
  localparam logic [7:0]  COL_FIRST     = 8'ha1;
  localparam logic [6:0]  ROW_CHARS     = 7'd94;
  localparam logic [12:0] HZ_BASE       = 13'd846;
  localparam logic [23:0] ASCII_BASE    = 24'h03b5c0;

  localparam logic [5:0] POS_CMD     = 6'd0;
  localparam logic [5:0] POS_ADDR_HI = 6'd1;
  localparam logic [5:0] POS_ADDR_MD = 6'd2;
  localparam logic [5:0] POS_ADDR_LO = 6'd3;

  typedef struct packed {
    logic        is_bitmap;
    logic        wide;
    logic [23:0] addr;
    logic [7:0]  data;
    logic [4:0]  idx;
    logic        fin;
  } job_t;

  typedef struct packed {
    logic empty;
    job_t head;
  } q_status_t;

endpackage
`default_nettype wire

/* rtl/fgf_front.sv */
// Front end: accepts items, tracks the read in progress and builds jobs.
`default_nettype none
module fgf_front (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         acc,
  input  wire logic [1:0]   cmd,
  input  wire logic [15:0]  char_code,
  input  wire logic [7:0]   rx_byte,
  output logic              push,
  output fgf_pkg::job_t     job
);
  import fgf_pkg::*;

  logic       busy_r, busy_nxt;
  logic [5:0] rcv_cnt_r, rcv_cnt_nxt;
  logic [5:0] glyph_bytes_r, glyph_bytes_nxt;

  logic [7:0]  row, col;
  logic        hz_hit, sym_hit;
  logic [6:0]  row_off;
  logic [12:0] glyph_num;
  logic [23:0] gbk_addr, ascii_addr;
  logic [4:0]  idx;
  logic        fin;

  always_comb begin
    row = char_code[15:8];
    col = char_code[7:0];
    hz_hit  = (row >= HZ_ROW_FIRST) && (row <= HZ_ROW_LAST) && (col >= COL_FIRST);
    sym_hit = (row >= SYM_ROW_FIRST) && (row <= SYM_ROW_LAST) && (col >= COL_FIRST);
    row_off = hz_hit ? 7'(row - HZ_ROW_FIRST) : 7'(row - SYM_ROW_FIRST);
    glyph_num = (13'(row_off) * 13'(ROW_CHARS)) + 13'(col - COL_FIRST)
              + (hz_hit ? HZ_BASE : 13'd0);
    gbk_addr = (hz_hit || sym_hit) ? {6'd0, glyph_num, 5'd0} : 24'd0;
    ascii_addr = {12'd0, char_code[7:0], 4'd0} + ASCII_BASE;
    idx = 5'(rcv_cnt_r - 6'(HEADER_BYTES));
    fin = (rcv_cnt_r - 6'(HEADER_BYTES - 1)) >= glyph_bytes_r;
  end

  always_comb begin
    busy_nxt        = busy_r;
    rcv_cnt_nxt     = rcv_cnt_r;
    glyph_bytes_nxt = glyph_bytes_r;
    push            = 1'b0;
    job.is_bitmap   = 1'b0;
    job.wide        = 1'b0;
    job.addr        = gbk_addr;
    job.data        = rx_byte;
    job.idx         = idx;
    job.fin         = fin;
    if (acc) begin
      case (cmd_t'(cmd))
        CMD_GBK, CMD_ASCII: begin
          if (!busy_r) begin
            push            = 1'b1;
            job.wide        = (cmd_t'(cmd) == CMD_GBK);
            job.addr        = (cmd_t'(cmd) == CMD_GBK) ? gbk_addr : ascii_addr;
            busy_nxt        = 1'b1;
            rcv_cnt_nxt     = 6'd0;
            glyph_bytes_nxt = (cmd_t'(cmd) == CMD_GBK) ? 6'(WIDE_GLYPH_BYTES)
                                                        : 6'(NARROW_GLYPH_BYTES);
          end
        end
        CMD_RX: begin
          if (busy_r) begin
            if (rcv_cnt_r < 6'(HEADER_BYTES)) begin
              rcv_cnt_nxt = rcv_cnt_r + 6'd1;
            end else begin
              push          = 1'b1;
              job.is_bitmap = 1'b1;
              if (fin) begin
                busy_nxt        = 1'b0;
                rcv_cnt_nxt     = 6'd0;
                glyph_bytes_nxt = 6'd0;
              end else begin
                rcv_cnt_nxt = rcv_cnt_r + 6'd1;
              end
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r        <= 1'b0;
      rcv_cnt_r     <= 6'd0;
      glyph_bytes_r <= 6'd0;
    end else begin
      busy_r        <= busy_nxt;
      rcv_cnt_r     <= rcv_cnt_nxt;
      glyph_bytes_r <= glyph_bytes_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/fgf_queue.sv */
// Small job queue between the front end and the back end.
`default_nettype none
module fgf_queue #(
  parameter int unsigned DEPTH = 4
) (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire fgf_pkg::job_t push_job,
  input  wire logic          pop,
  output logic               full,
  output fgf_pkg::q_status_t status
);
  import fgf_pkg::*;

  localparam int unsigned PtrW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CntW = $clog2(DEPTH + 1);

  job_t            mem_r [DEPTH];
  logic [PtrW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PtrW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CntW-1:0] cnt_r, cnt_nxt;

  always_comb begin
    full         = (cnt_r == CntW'(DEPTH));
    status.empty = (cnt_r == '0);
    status.head  = mem_r[rd_ptr_r];
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PtrW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PtrW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

/* rtl/fgf_back.sv */
// Back end: expands jobs into output items and holds the output register.
`default_nettype none
module fgf_back (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire fgf_pkg::q_status_t status,
  output logic                    pop,
  output logic                    out_tvalid,
  input  wire logic               out_tready,
  output logic [15:0]             out_tdata,
  output logic                    out_tuser,
  output logic                    out_tlast
);
  import fgf_pkg::*;

  logic       active_r, active_nxt;
  logic [5:0] pos_r, pos_nxt;
  job_t       cur_r, cur_nxt;

  logic       out_valid_r, out_valid_nxt;
  logic       out_kind_r, out_kind_nxt;
  logic [7:0] out_byte_r, out_byte_nxt;
  logic [4:0] out_idx_r, out_idx_nxt;
  logic       out_sel_r, out_sel_nxt;
  logic       out_last_r, out_last_nxt;

  logic [5:0] end_pos;
  logic       at_end, emit;
  logic [7:0] tx_byte;

  always_comb begin
    if (cur_r.is_bitmap) begin
      end_pos = 6'd0;
    end else if (cur_r.wide) begin
      end_pos = 6'(HEADER_BYTES + WIDE_GLYPH_BYTES - 1);
    end else begin
      end_pos = 6'(HEADER_BYTES + NARROW_GLYPH_BYTES - 1);
    end
    at_end = (pos_r == end_pos);
    emit   = active_r && (!out_valid_r || out_tready);
    pop    = !status.empty && (!active_r || (emit && at_end));
    case (pos_r)
      POS_CMD:     tx_byte = ROM_READ_CMD;
      POS_ADDR_HI: tx_byte = cur_r.addr[23:16];
      POS_ADDR_MD: tx_byte = cur_r.addr[15:8];
      POS_ADDR_LO: tx_byte = cur_r.addr[7:0];
      default:     tx_byte = DUMMY_BYTE;
    endcase
  end

  always_comb begin
    active_nxt = active_r;
    pos_nxt    = pos_r;
    cur_nxt    = cur_r;
    if (emit) begin
      pos_nxt = pos_r + 6'd1;
      if (at_end) begin
        active_nxt = 1'b0;
      end
    end
    if (pop) begin
      active_nxt = 1'b1;
      pos_nxt    = 6'd0;
      cur_nxt    = status.head;
    end
  end

  always_comb begin
    out_valid_nxt = out_valid_r && !out_tready;
    out_kind_nxt  = out_kind_r;
    out_byte_nxt  = out_byte_r;
    out_idx_nxt   = out_idx_r;
    out_sel_nxt   = out_sel_r;
    out_last_nxt  = out_last_r;
    if (emit) begin
      out_valid_nxt = 1'b1;
      if (cur_r.is_bitmap) begin
        out_kind_nxt = 1'b1;
        out_byte_nxt = cur_r.data;
        out_idx_nxt  = cur_r.idx;
        out_sel_nxt  = !cur_r.fin;
        out_last_nxt = cur_r.fin;
      end else begin
        out_kind_nxt = 1'b0;
        out_byte_nxt = tx_byte;
        out_idx_nxt  = 5'd0;
        out_sel_nxt  = 1'b1;
        out_last_nxt = at_end;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= 1'b0;
      pos_r       <= 6'd0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      pos_r       <= pos_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    cur_r      <= cur_nxt;
    out_kind_r <= out_kind_nxt;
    out_byte_r <= out_byte_nxt;
    out_idx_r  <= out_idx_nxt;
    out_sel_r  <= out_sel_nxt;
    out_last_r <= out_last_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {2'b00, out_sel_r, out_idx_r, out_byte_r};
  assign out_tuser  = out_kind_r;
  assign out_tlast  = out_last_r;

  a_pos_range: assert property (@(posedge clk) disable iff (!rst_n)
    active_r |-> (pos_r <= end_pos))
    else $error("Back end position ran past the end of its job.");

  a_bitmap_select: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r) |-> (out_sel_r == !out_last_r))
    else $error("Bitmap item released chip select without ending the read.");

  a_tx_select: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_kind_r) |-> (out_sel_r && (out_idx_r == 5'd0)))
    else $error("Transmit item with chip select released or a nonzero index.");

  a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (!active_r || (emit && at_end)))
    else $error("Job loaded while the current job was still running.");

endmodule
`default_nettype wire

/* rtl/font_rom_glyph_fetch_top.sv */
// Top level of the font ROM glyph fetch block.
// A glyph request (GBK 16x16 or ASCII 8x16) produces the transmit items of one
// ROM read: command 0x03, three address bytes and 32 or 16 dummy bytes; each
// receive byte after the four header answers comes back as a numbered bitmap
// item. Input items are taken one per cycle while the job queue (QUEUE_DEPTH
// entries) has room; the back end emits one output item per cycle while the
// output is not stalled, so a request gives 36 (GBK) or 20 (ASCII) output items
// and a bitmap byte one. Items that cause no result never enter the queue.
`default_nettype none
module font_rom_glyph_fetch_top #(
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // char_code[15:0], rx_byte[23:16]
  input  wire logic [1:0]  in_tuser,   // cmd[1:0]
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [15:0]      out_tdata,  // byte_value[7:0], bitmap_index[12:8],
                                       // select_active[13], zero[15:14]
  output logic             out_tuser,  // kind[0]
  output logic             out_tlast
);
  import fgf_pkg::*;

  logic      q_full;
  logic      push;
  logic      pop;
  job_t      job;
  q_status_t q_status;

  assign in_tready = !q_full;

  fgf_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .acc       (in_tvalid && in_tready),
    .cmd       (in_tuser),
    .char_code (in_tdata[15:0]),
    .rx_byte   (in_tdata[23:16]),
    .push      (push),
    .job       (job)
  );

  fgf_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (job),
    .pop      (pop),
    .full     (q_full),
    .status   (q_status)
  );

  fgf_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .status     (q_status),
    .pop        (pop),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

endmodule
`default_nettype wire
